@@ rtl/gcfb_pkg.sv @@
// ----------------------------------------------------------------------------
// gcfb_pkg
// Shared field widths and controller/datapath interface types for the
// greedy conflict-free binning unit.
// ----------------------------------------------------------------------------
package gcfb_pkg;

	// fixed field widths of the input and result words
	localparam int ATOM_W  = 6;
	localparam int MASK_W  = 64;
	localparam int BIN_W   = 6;
	localparam int COUNT_W = 7;

	// commands from controller to datapath
	typedef struct packed {
		logic load;   // capture the input word
		logic scan;   // issue a bin read and check the previous one
		logic place;  // write the atom into the chosen bin, post result
	} ctl_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic hit;        // checked bin holds no conflicting atom
		logic exhausted;  // last open bin checked without a fit
	} ctl_sts_t;

endpackage

@@ rtl/gcfb_ram.sv @@
// ----------------------------------------------------------------------------
// gcfb_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module gcfb_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/gcfb_ctrl.sv @@
// ----------------------------------------------------------------------------
// gcfb_ctrl
// Controller for the binning unit: takes a word, sequences the bin scan and
// the write-back, and reports busy.
// ----------------------------------------------------------------------------
module gcfb_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               start_req,
	input  gcfb_pkg::ctl_sts_t sts,
	output gcfb_pkg::ctl_cmd_t cmd,
	output logic               busy
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_PLACE = 3'b100
	} state_t;

	state_t state_q;
	state_t state_nx;

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_nx = start_req ? ST_PLACE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.hit || sts.exhausted) begin
					state_nx = ST_PLACE;
				end
			end
			ST_PLACE: begin
				state_nx = ST_IDLE;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// datapath commands
	always_comb begin
		cmd.load  = (state_q == ST_IDLE) && start;
		cmd.scan  = (state_q == ST_SCAN);
		cmd.place = (state_q == ST_PLACE);
	end

	assign busy = (state_q != ST_IDLE);

endmodule

@@ rtl/gcfb_datapath.sv @@
// ----------------------------------------------------------------------------
// gcfb_datapath
// Bin membership RAM with per-bin valid bits, scan pointers, open bin count,
// write-back logic and result registers.
// ----------------------------------------------------------------------------
module gcfb_datapath #(
	parameter int MAX_ATOMS = 64,
	parameter int MAX_BINS  = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  gcfb_pkg::ctl_cmd_t           cmd,
	output gcfb_pkg::ctl_sts_t           sts,
	input  logic                         start_req,
	input  logic [gcfb_pkg::ATOM_W-1:0]  atom_id,
	input  logic [gcfb_pkg::MASK_W-1:0]  neighbor_mask,
	output logic                         done,
	output logic [gcfb_pkg::BIN_W-1:0]   bin_index,
	output logic [gcfb_pkg::COUNT_W-1:0] bins_in_use,
	output logic                         overflow
);

	localparam int BIN_AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
	localparam int OPEN_W = $clog2(MAX_BINS + 1);

	// captured word
	logic                 start_q;
	logic [MAX_ATOMS-1:0] mask_q;
	logic                 empty_q;
	logic [MAX_ATOMS-1:0] abit_q;

	// scan state
	logic [BIN_AW-1:0]    rd_ptr_q;
	logic [BIN_AW-1:0]    chk_ptr_q;
	logic                 rd_vld_q;
	logic [BIN_AW-1:0]    chosen_q;
	logic [MAX_ATOMS-1:0] old_q;
	logic                 newbin_q;

	// bin state
	logic [OPEN_W-1:0]    open_q;
	logic [OPEN_W-1:0]    open_nx;
	logic [MAX_BINS-1:0]  valid_q;

	// results
	logic                         done_q;
	logic [gcfb_pkg::BIN_W-1:0]   bin_q;
	logic [gcfb_pkg::COUNT_W-1:0] count_q;
	logic                         ovf_q;

	logic [MAX_ATOMS-1:0] in_mask;
	logic [MAX_ATOMS-1:0] in_abit;
	logic [BIN_AW-1:0]    last_bin;
	logic [MAX_ATOMS-1:0] rdata;
	logic [MAX_ATOMS-1:0] rdata_eff;
	logic                 ovf_w;
	logic                 we;
	logic [BIN_AW-1:0]    waddr;
	logic [MAX_ATOMS-1:0] wdata;

	// input word trimmed to the atom range
	assign in_mask  = neighbor_mask[MAX_ATOMS-1:0];
	assign in_abit  = {{(MAX_ATOMS-1){1'b0}}, 1'b1} << atom_id;
	assign last_bin = BIN_AW'(open_q - 1'b1);

	// membership store
	gcfb_ram #(
		.WIDTH (MAX_ATOMS),
		.DEPTH (MAX_BINS)
	) u_bin_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (rd_ptr_q),
		.rdata (rdata)
	);

	// a bin never written since the last clear reads as empty
	assign rdata_eff = valid_q[chk_ptr_q] ? rdata : '0;

	// fit check on the word read back in the previous cycle
	always_comb begin
		sts.hit       = rd_vld_q && (empty_q || ((rdata_eff & mask_q) == '0));
		sts.exhausted = rd_vld_q && !sts.hit && (chk_ptr_q == last_bin);
	end

	// write-back selection
	always_comb begin
		ovf_w = !start_q && newbin_q && (open_q == OPEN_W'(MAX_BINS));
		we    = cmd.place && !ovf_w;
		waddr = start_q ? '0 : chosen_q;
		wdata = start_q ? abit_q : (old_q | abit_q);
	end

	// open bin count after this placement
	always_comb begin
		open_nx = open_q;
		if (cmd.place) begin
			if (start_q) begin
				open_nx = OPEN_W'(1);
			end else if (we && newbin_q) begin
				open_nx = open_q + 1'b1;
			end
		end
	end

	// capture and scan registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			start_q  <= start_req;
			mask_q   <= in_mask;
			empty_q  <= (in_mask == '0);
			abit_q   <= in_abit;
			rd_ptr_q <= (in_mask == '0) ? last_bin : '0;
		end else if (cmd.scan) begin
			chk_ptr_q <= rd_ptr_q;
			if (rd_ptr_q != last_bin) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (sts.hit) begin
				chosen_q <= chk_ptr_q;
				old_q    <= rdata_eff;
				newbin_q <= 1'b0;
			end else if (sts.exhausted) begin
				chosen_q <= BIN_AW'(open_q);
				old_q    <= '0;
				newbin_q <= 1'b1;
			end
		end
	end

	// read pipeline flag, open count, valid bits and done strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_q <= 1'b0;
			open_q   <= OPEN_W'(1);
			valid_q  <= '0;
			done_q   <= 1'b0;
		end else begin
			rd_vld_q <= cmd.scan;
			open_q   <= open_nx;
			done_q   <= cmd.place;
			if (cmd.place && start_q) begin
				valid_q <= MAX_BINS'(1);
			end else if (we) begin
				valid_q[chosen_q] <= 1'b1;
			end
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (cmd.place) begin
			bin_q   <= ovf_w ? '0 : gcfb_pkg::BIN_W'(waddr);
			count_q <= gcfb_pkg::COUNT_W'(open_nx);
			ovf_q   <= ovf_w;
		end
	end

	assign done        = done_q;
	assign bin_index   = bin_q;
	assign bins_in_use = count_q;
	assign overflow    = ovf_q;

endmodule

@@ rtl/greedy_conflict_free_binning_unit.sv @@
// ----------------------------------------------------------------------------
// greedy_conflict_free_binning_unit
// Greedy first-fit binning of atoms so that no bin holds two interacting
// atoms.
// ----------------------------------------------------------------------------
// One word is taken when start is high and busy is low. A word with start_req
// set empties every bin and places its atom in bin 0; busy stays high for one
// cycle. Any other word scans the bin RAM one bin per cycle from bin 0
// until an open bin fits or the last open bin has been checked; a word
// with an empty neighbor mask goes straight to the newest bin. The result
// shows on bin_index, bins_in_use and overflow with done high for a single
// cycle as busy falls; the receiver must take it then. A new
// word may be given in that same cycle.
// ----------------------------------------------------------------------------
module greedy_conflict_free_binning_unit #(
	parameter int MAX_ATOMS = 64,
	parameter int MAX_BINS  = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         start_req,
	input  logic [gcfb_pkg::ATOM_W-1:0]  atom_id,
	input  logic [gcfb_pkg::MASK_W-1:0]  neighbor_mask,
	output logic                         done,
	output logic [gcfb_pkg::BIN_W-1:0]   bin_index,
	output logic [gcfb_pkg::COUNT_W-1:0] bins_in_use,
	output logic                         overflow
);

	gcfb_pkg::ctl_cmd_t cmd;
	gcfb_pkg::ctl_sts_t sts;

	// sequencer
	gcfb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.start_req (start_req),
		.sts       (sts),
		.cmd       (cmd),
		.busy      (busy)
	);

	// bin store and result path
	gcfb_datapath #(
		.MAX_ATOMS (MAX_ATOMS),
		.MAX_BINS  (MAX_BINS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.start_req     (start_req),
		.atom_id       (atom_id),
		.neighbor_mask (neighbor_mask),
		.done          (done),
		.bin_index     (bin_index),
		.bins_in_use   (bins_in_use),
		.overflow      (overflow)
	);

endmodule

@@ rtl/gcfb_checker.sv @@
// ----------------------------------------------------------------------------
// gcfb_checker
// Port-level checks on the binning unit: busy/done sequencing and result
// ranges, attached to the top level by bind.
// ----------------------------------------------------------------------------
module gcfb_checker #(
	parameter int MAX_BINS = 64
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         done,
	input logic [gcfb_pkg::BIN_W-1:0]   bin_index,
	input logic [gcfb_pkg::COUNT_W-1:0] bins_in_use,
	input logic                         overflow
);

	// an accepted word keeps the unit busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	// a result is posted only once the unit is idle again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result posted while busy");

	// one strobe per word
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// bin count stays within range
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (bins_in_use >= gcfb_pkg::COUNT_W'(1)) &&
			(bins_in_use <= gcfb_pkg::COUNT_W'(MAX_BINS)))
		else $error("bins_in_use out of range");

	// overflow reports bin 0 with every bin in use
	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		done && overflow |-> (bin_index == '0) &&
			(bins_in_use == gcfb_pkg::COUNT_W'(MAX_BINS)))
		else $error("overflow result malformed");

endmodule

bind greedy_conflict_free_binning_unit gcfb_checker #(
	.MAX_BINS (MAX_BINS)
) u_gcfb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.bin_index   (bin_index),
	.bins_in_use (bins_in_use),
	.overflow    (overflow)
);
